// ===== design/dkcht_pkg.sv =====
// package for the distinct key counting hash table
// holds widths, hash constants, the queue entry and result types and the prime multiply; no dependencies
`default_nettype none
package dkcht_pkg;
	localparam int INDEX_BITS = 12;
	localparam int KEY_BITS = 49;
	localparam int COUNT_BITS = 32;
	localparam int TOTAL_BITS = INDEX_BITS + 1;
	localparam int TABLE_SIZE = 1 << INDEX_BITS;
	localparam int SLOT_BITS = 1 + 2 * KEY_BITS + 2 * COUNT_BITS;
	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
	localparam int HIGH_SHIFT = 32;

	typedef struct packed {
		logic [KEY_BITS-1:0] key_first;
		logic [KEY_BITS-1:0] key_second;
		logic flagged;
		logic [INDEX_BITS-1:0] start;
	} job_t;

	typedef struct packed {
		logic was_new;
		logic table_full;
		logic [COUNT_BITS-1:0] entry_hits;
		logic [COUNT_BITS-1:0] entry_flagged_hits;
		logic [TOTAL_BITS-1:0] distinct_total;
	} res_t;

	// multiply by the fnv prime: 2^40 + 2^8 + 0xb3, shifts and adds only
	// 0xb3 = 2^7 + 2^5 + 2^4 + 2^1 + 1
	function automatic logic [63:0] mul_prime(input logic [63:0] h);
		mul_prime = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4)
			+ (h << 1) + h;
	endfunction
endpackage
`default_nettype wire

// ===== design/dkcht_if.sv =====
// valid/ready channel carrying one payload of type T
// depends on nothing
`default_nettype none
interface dkcht_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/distinct_key_counting_hash_table.sv =====
// Counts distinct two-word keys in a 4096-slot linear-probing table. After reset
// a clearing pass writes every slot before the first result. The hasher takes
// one key at a time, through the accept step and four FNV multiply steps, and
// stalls its last step while the queue is full; a two-entry queue feeds the
// prober, which takes a job, reads then checks each slot visited on the
// single-port slot ram, then holds the result until taken. A full table with
// no match reports table_full and is left unchanged. Counts saturate at 2^32-1.
// depends on dkcht_pkg, dkcht_if, dkcht_front, dkcht_back
`default_nettype none
module distinct_key_counting_hash_table (
	input wire logic clk,
	input wire logic arst_n,
	dkcht_if.sink in_ch,
	dkcht_if.source out_ch
);
	import dkcht_pkg::*;

	logic job_valid, job_ready;
	job_t job;
	res_t res;

	dkcht_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.key_first(in_ch.data.key_first), .key_second(in_ch.data.key_second),
		.flagged(in_ch.data.flagged), .job_valid(job_valid), .job_ready(job_ready),
		.job(job)
	);

	dkcht_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready),
		.job(job), .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
	);

	assign out_ch.data = res;

	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(res.was_new && res.table_full)) else $error("new and full");
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && res.table_full |-> res.entry_hits == '0) else $error("full hits");
	a_new_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && res.was_new |-> res.entry_hits == 32'd1) else $error("new hits");
endmodule
`default_nettype wire

// ===== design/dkcht_ram.sv =====
// generic single port ram, registered read
// depends on nothing
`default_nettype none
module dkcht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== design/dkcht_front.sv =====
// front end: accepts keys, hashes them one at a time in an iterative hasher, queues jobs
// depends on dkcht_pkg
`default_nettype none
module dkcht_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [dkcht_pkg::KEY_BITS-1:0] key_first,
	input wire logic [dkcht_pkg::KEY_BITS-1:0] key_second,
	input wire logic flagged,
	output logic job_valid,
	input wire logic job_ready,
	output dkcht_pkg::job_t job
);
	import dkcht_pkg::*;

	// one hash step per cycle but for the last, which waits for queue room; one item in the hasher at a time
	logic busy_q;
	logic [1:0] step_q;
	logic [63:0] h_q;
	logic [KEY_BITS-1:0] a_q, b_q;
	logic f_q;
	logic [63:0] mix;
	logic [1:0] q_cnt_q;
	logic q_rd_q, q_wr_q;
	job_t q_mem_q [2];
	logic push;

	assign in_ready = !busy_q;
	assign push = busy_q && step_q == 2'd3;

	always_comb begin
		case (step_q)
			2'd0: mix = h_q ^ 64'(a_q);
			2'd1: mix = h_q ^ 64'(b_q);
			2'd2: mix = h_q ^ (64'(a_q) >> HIGH_SHIFT);
			default: mix = h_q ^ (64'(b_q) >> HIGH_SHIFT);
		endcase
	end

	// stall the last step while the queue is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end
		end else if (step_q != 2'd3) begin
			step_q <= step_q + 2'd1;
		end else if (q_cnt_q != 2'd2) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			a_q <= key_first;
			b_q <= key_second;
			f_q <= flagged;
			h_q <= FNV_BASIS;
		end else if (step_q != 2'd3) begin
			h_q <= mul_prime(mix);
		end
	end

	logic do_push, do_pop;
	logic [63:0] hfin;
	assign hfin = mul_prime(mix);
	assign do_push = push && q_cnt_q != 2'd2;
	assign do_pop = job_valid && job_ready;
	assign job_valid = q_cnt_q != 2'd0;
	assign job = q_mem_q[q_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= 2'd0;
			q_rd_q <= 1'b0;
			q_wr_q <= 1'b0;
		end else begin
			if (do_push) q_wr_q <= !q_wr_q;
			if (do_pop) q_rd_q <= !q_rd_q;
			q_cnt_q <= q_cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) q_mem_q[q_wr_q] <= '{key_first: a_q, key_second: b_q,
			flagged: f_q, start: hfin[INDEX_BITS-1:0]};
	end
endmodule
`default_nettype wire

// ===== design/dkcht_back.sv =====
// back end: linear probe with read-modify-write on the slot ram
// depends on dkcht_pkg and dkcht_ram
`default_nettype none
module dkcht_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_ready,
	input dkcht_pkg::job_t job,
	output logic res_valid,
	input wire logic res_ready,
	output dkcht_pkg::res_t res
);
	import dkcht_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0] state_q;
	job_t job_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [INDEX_BITS:0] probes_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic we;
	logic [INDEX_BITS-1:0] addr;
	logic [SLOT_BITS-1:0] wdata, rdata;
	logic r_used;
	logic [KEY_BITS-1:0] r_a, r_b;
	logic [COUNT_BITS-1:0] r_h, r_f, n_h, n_f;
	logic hit;

	assign {r_used, r_a, r_b, r_h, r_f} = rdata;
	assign hit = r_a == job_q.key_first && r_b == job_q.key_second;
	assign n_h = (&r_h) ? r_h : r_h + 1'b1;
	assign n_f = (job_q.flagged && !(&r_f)) ? r_f + 1'b1 : r_f;

	dkcht_ram #(.WIDTH(SLOT_BITS), .DEPTH(TABLE_SIZE)) u_slots (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_comb begin
		we = 1'b0;
		addr = idx_q;
		wdata = '0;
		unique case (state_q)
			S_CLEAR: we = 1'b1;
			S_CHECK: begin
				if (!r_used) begin
					we = 1'b1;
					wdata = {1'b1, job_q.key_first, job_q.key_second,
						COUNT_BITS'(1), COUNT_BITS'(job_q.flagged)};
				end else if (hit) begin
					we = 1'b1;
					wdata = {1'b1, r_a, r_b, n_h, n_f};
				end
			end
			default: ;
		endcase
	end

	assign job_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (&idx_q) state_q <= S_IDLE;
				end
				S_IDLE: if (job_valid) begin
					idx_q <= job.start;
					probes_q <= '0;
					state_q <= S_READ;
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (!r_used) begin
						res <= '{was_new: 1'b1, table_full: 1'b0, entry_hits: COUNT_BITS'(1),
							entry_flagged_hits: COUNT_BITS'(job_q.flagged),
							distinct_total: total_q + 1'b1};
						total_q <= total_q + 1'b1;
						state_q <= S_OUT;
					end else if (hit) begin
						res <= '{was_new: 1'b0, table_full: 1'b0, entry_hits: n_h,
							entry_flagged_hits: n_f, distinct_total: total_q};
						state_q <= S_OUT;
					end else if (probes_q == (INDEX_BITS+1)'(TABLE_SIZE - 1)) begin
						res <= '{was_new: 1'b0, table_full: 1'b1, entry_hits: '0,
							entry_flagged_hits: '0, distinct_total: total_q};
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						probes_q <= probes_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_OUT: if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && job_valid) job_q <= job;
	end
endmodule
`default_nettype wire
